// ===== hdl/scs_pkg.sv =====
// ----------------------------------------------------------------------------
// scs_pkg
// Shared types, widths and helper functions of the channel synthesis block.
// ----------------------------------------------------------------------------
`default_nettype none

package scs_pkg;

    localparam int PORT_W    = 3;
    localparam int NC_W      = 7;
    localparam int NP_W      = 4;
    localparam int VAL_W     = 24;
    localparam int DLY_W     = 32;
    localparam int FC_W      = 37;
    localparam int PSD_W     = 32;
    localparam int OUT_W     = 40;
    localparam int ACC_W     = 48;
    localparam int PH_W      = 18;
    localparam int TRIG_W    = 16;
    localparam int ROOT_W    = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    typedef enum logic [1:0] {
        OP_COEF    = 2'd0,
        OP_CLUSTER = 2'd1,
        OP_RB      = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CLUSTERS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_RX       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_TX       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE      = 3'd3;

    typedef struct packed {
        op_t                      op;
        logic [4:0]               cluster;
        logic [PORT_W-1:0]        row;
        logic [PORT_W-1:0]        col;
        logic signed [VAL_W-1:0]  value_re;
        logic signed [VAL_W-1:0]  value_im;
        logic [DLY_W-1:0]         delay;
        logic [FC_W-1:0]          center_hz;
        logic [PSD_W-1:0]         psd;
    } cmd_t;

    typedef struct packed {
        logic [NC_W-1:0] nc;
        logic [NP_W-1:0] nr;
        logic [NP_W-1:0] nt;
    } dims_t;

    typedef struct packed {
        logic signed [PH_W-1:0] re;
        logic signed [PH_W-1:0] im;
    } phasor_t;

    function automatic logic signed [TRIG_W-1:0] sat16(input logic signed [23:0] v);
        logic signed [TRIG_W-1:0] r;
        if (v > 24'sd32767)
            r = 16'sh7fff;
        else if (v < -24'sd32768)
            r = 16'sh8000;
        else
            r = v[TRIG_W-1:0];
        return r;
    endfunction

    // Taylor term divisors: sine (2k)(2k+1), cosine (2k-1)(2k)
    function automatic logic [7:0] taylor_div(input logic is_cos, input logic [2:0] k);
        logic [7:0] d;
        case ({is_cos, k})
            4'b0001: d = 8'd6;
            4'b0010: d = 8'd20;
            4'b0011: d = 8'd42;
            4'b0100: d = 8'd72;
            4'b0101: d = 8'd110;
            4'b1001: d = 8'd2;
            4'b1010: d = 8'd12;
            4'b1011: d = 8'd30;
            4'b1100: d = 8'd56;
            4'b1101: d = 8'd90;
            4'b1110: d = 8'd132;
            default: d = 8'd1;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/scs_front.sv =====
// ----------------------------------------------------------------------------
// scs_front
// Accepts input transactions, drops loads outside the stores and unused
// opcodes, applies the transpose and queues the rest for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module scs_front
    import scs_pkg::*;
#(
    parameter int MAX_CLUSTERS = 32,
    parameter int MAX_PORTS    = 8
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [1:0]              opcode,
    input  wire logic [4:0]              cluster,
    input  wire logic [PORT_W-1:0]       row,
    input  wire logic [PORT_W-1:0]       col,
    input  wire logic signed [VAL_W-1:0] value_re,
    input  wire logic signed [VAL_W-1:0] value_im,
    input  wire logic [DLY_W-1:0]        delay,
    input  wire logic [FC_W-1:0]         center_hz,
    input  wire logic [PSD_W-1:0]        psd,
    input  wire logic                    reverse,
    output logic                         q_valid,
    input  wire logic                    q_pop,
    output cmd_t                         q_cmd
);

    localparam int DEPTH = 4;
    localparam int PTR_W = 2;

    cmd_t              fifo_mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]    count_reg, count_next;
    logic              keep;
    logic              push;
    logic              pop;
    logic [PORT_W-1:0] r_sw;
    logic [PORT_W-1:0] c_sw;
    cmd_t              cmd_in;

    assign r_sw = reverse ? col : row;
    assign c_sw = reverse ? row : col;

    always_comb
    begin
        unique case (op_t'(opcode))
            OP_COEF:    keep = (int'(cluster) < MAX_CLUSTERS) && (int'(r_sw) < MAX_PORTS)
                               && (int'(c_sw) < MAX_PORTS);
            OP_CLUSTER: keep = (int'(cluster) < MAX_CLUSTERS);
            OP_RB:      keep = 1'b1;
            default:    keep = 1'b0;
        endcase
    end

    always_comb
    begin
        cmd_in.op        = op_t'(opcode);
        cmd_in.cluster   = cluster;
        cmd_in.row       = r_sw;
        cmd_in.col       = c_sw;
        cmd_in.value_re  = value_re;
        cmd_in.value_im  = value_im;
        cmd_in.delay     = delay;
        cmd_in.center_hz = center_hz;
        cmd_in.psd       = psd;
    end

    assign in_ready = (count_reg != (PTR_W + 1)'(DEPTH));
    assign push     = in_valid && in_ready && keep;
    assign pop      = q_pop && q_valid;
    assign q_valid  = (count_reg != '0);
    assign q_cmd    = fifo_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_mem[wr_ptr_reg] <= cmd_in;
    end

endmodule

`default_nettype wire

// ===== hdl/scs_phasor.sv =====
// ----------------------------------------------------------------------------
// scs_phasor
// Cluster phasor unit: delay phase, cos/sin by Taylor series with a serial
// constant divider, then the product with the Doppler phasor.
// ----------------------------------------------------------------------------
`default_nettype none

module scs_phasor
    import scs_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [FC_W-1:0]          fc,
    input  wire logic [DLY_W-1:0]         delay,
    input  wire logic signed [TRIG_W-1:0] dop_c,
    input  wire logic signed [TRIG_W-1:0] dop_s,
    output logic                          done,
    output phasor_t                       phasor
);

    typedef enum logic [10:0] {
        P_IDLE  = 11'b00000000001,
        P_MUL   = 11'b00000000010,
        P_SUM   = 11'b00000000100,
        P_XMUL  = 11'b00000001000,
        P_X2    = 11'b00000010000,
        P_TMUL  = 11'b00000100000,
        P_DIV   = 11'b00001000000,
        P_ACC   = 11'b00010000000,
        P_ROUND = 11'b00100000000,
        P_MRE   = 11'b01000000000,
        P_MIM   = 11'b10000000000
    } pstate_t;

    localparam logic [31:0] ONE_Q30   = 32'h4000_0000;
    localparam logic [3:0]  DIV_STEPS = 4'd8;

    pstate_t                   state_reg, state_next;
    logic                      done_reg;
    logic [47:0]               lo_reg;
    logic [31:0]               hi_reg;
    logic [1:0]                q_reg;
    logic [13:0]               r_reg;
    logic [30:0]               x_reg;
    logic [31:0]               x2_reg;
    logic [31:0]               t_reg;
    logic signed [33:0]        acc_reg;
    logic signed [33:0]        sacc_reg;
    logic [2:0]                k_reg;
    logic                      cos_reg;
    logic [35:0]               dvd_reg;
    logic [7:0]                rem_reg;
    logic [3:0]                step_reg;
    logic signed [TRIG_W-1:0]  tc_reg;
    logic signed [TRIG_W-1:0]  ts_reg;
    phasor_t                   ph_reg;

    logic [47:0]               phase_w;
    logic [47:0]               neg_w;
    logic [44:0]               xprod_w;
    logic [61:0]               x2prod_w;
    logic [63:0]               tprod_w;
    logic [7:0]                div_w;
    logic [8:0]                rem_w;
    logic [35:0]               dvd_w;
    logic [31:0]               tq_w;
    logic signed [33:0]        acc_new_w;
    logic                      term_end_w;
    logic [18:0]               sv_w;
    logic [18:0]               cv_w;
    logic signed [19:0]        cs_w;
    logic signed [19:0]        ss_w;
    logic signed [32:0]        mre_w;
    logic signed [32:0]        mim_w;

    assign phase_w  = lo_reg + {hi_reg, 16'd0};
    assign neg_w    = 48'd0 - phase_w;
    assign xprod_w  = 45'(r_reg) * 45'(HALF_PI_Q30);
    assign x2prod_w = 62'(x_reg) * 62'(x_reg);
    assign tprod_w  = 64'(t_reg) * 64'(x2_reg);
    assign div_w    = taylor_div(cos_reg, k_reg);

    // four restoring quotient bits per cycle
    always_comb
    begin
        rem_w = {1'b0, rem_reg};
        dvd_w = dvd_reg;
        for (int i = 0; i < 4; i++)
        begin
            rem_w = {rem_w[7:0], dvd_w[35]};
            dvd_w = {dvd_w[34:0], 1'b0};
            if (rem_w >= {1'b0, div_w})
            begin
                rem_w    = rem_w - {1'b0, div_w};
                dvd_w[0] = 1'b1;
            end
        end
    end

    assign tq_w       = dvd_reg[31:0];
    assign acc_new_w  = k_reg[0] ? acc_reg - $signed({2'b00, tq_w})
                                 : acc_reg + $signed({2'b00, tq_w});
    assign term_end_w = cos_reg ? (k_reg == 3'd6) : (k_reg == 3'd5);

    function automatic logic [18:0] round_q15(input logic signed [33:0] v);
        logic [33:0] u;
        u = v[33] ? 34'd0 : 34'(v) + 34'd16384;
        return u[33:15];
    endfunction

    assign sv_w = round_q15(sacc_reg);
    assign cv_w = round_q15(acc_reg);

    always_comb
    begin
        unique case (q_reg)
            2'd0:
            begin
                cs_w = $signed({1'b0, cv_w});
                ss_w = $signed({1'b0, sv_w});
            end
            2'd1:
            begin
                cs_w = -$signed({1'b0, sv_w});
                ss_w = $signed({1'b0, cv_w});
            end
            2'd2:
            begin
                cs_w = -$signed({1'b0, cv_w});
                ss_w = -$signed({1'b0, sv_w});
            end
            default:
            begin
                cs_w = $signed({1'b0, sv_w});
                ss_w = -$signed({1'b0, cv_w});
            end
        endcase
    end

    assign mre_w = 33'(tc_reg * dop_c) - 33'(ts_reg * dop_s);
    assign mim_w = 33'(tc_reg * dop_s) + 33'(ts_reg * dop_c);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            P_IDLE:  if (start) state_next = P_MUL;
            P_MUL:   state_next = P_SUM;
            P_SUM:   state_next = P_XMUL;
            P_XMUL:  state_next = P_X2;
            P_X2:    state_next = P_TMUL;
            P_TMUL:  state_next = P_DIV;
            P_DIV:   if (step_reg == DIV_STEPS) state_next = P_ACC;
            P_ACC:   state_next = (term_end_w && cos_reg) ? P_ROUND : P_TMUL;
            P_ROUND: state_next = P_MRE;
            P_MRE:   state_next = P_MIM;
            P_MIM:   state_next = P_IDLE;
            default: state_next = P_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= P_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == P_MIM);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            P_MUL:
            begin
                lo_reg <= 48'(fc[15:0]) * 48'(delay);
                hi_reg <= 32'(fc[FC_W-1:16] * delay);
            end
            P_SUM:
            begin
                q_reg <= neg_w[47:46];
                r_reg <= neg_w[45:32];
            end
            P_XMUL:
                x_reg <= xprod_w[44:14];
            P_X2:
            begin
                x2_reg  <= x2prod_w[61:30];
                t_reg   <= {1'b0, x_reg};
                acc_reg <= $signed({3'b000, x_reg});
                k_reg   <= 3'd1;
                cos_reg <= 1'b0;
            end
            P_TMUL:
            begin
                dvd_reg  <= {2'b00, tprod_w[63:30]};
                rem_reg  <= '0;
                step_reg <= '0;
            end
            P_DIV:
            begin
                dvd_reg  <= dvd_w;
                rem_reg  <= rem_w[7:0];
                step_reg <= step_reg + 1'b1;
            end
            P_ACC:
            begin
                if (term_end_w && !cos_reg)
                begin
                    // sine done, start cosine
                    sacc_reg <= acc_new_w;
                    t_reg    <= ONE_Q30;
                    acc_reg  <= $signed({2'b00, ONE_Q30});
                    k_reg    <= 3'd1;
                    cos_reg  <= 1'b1;
                end
                else
                begin
                    t_reg   <= tq_w;
                    acc_reg <= acc_new_w;
                    k_reg   <= k_reg + 1'b1;
                end
            end
            P_ROUND:
            begin
                tc_reg <= sat16({{4{cs_w[19]}}, cs_w});
                ts_reg <= sat16({{4{ss_w[19]}}, ss_w});
            end
            P_MRE:
                ph_reg.re <= PH_W'(mre_w >>> 15);
            P_MIM:
                ph_reg.im <= PH_W'(mim_w >>> 15);
            default:
            begin
            end
        endcase
    end

    assign done   = done_reg;
    assign phasor = ph_reg;

endmodule

`default_nettype wire

// ===== hdl/scs_back.sv =====
// ----------------------------------------------------------------------------
// scs_back
// Executes queued commands: store loads, and per resource block the square
// root, per-cluster phasor, pair MAC into the accumulators and readout.
// ----------------------------------------------------------------------------
`default_nettype none

module scs_back
    import scs_pkg::*;
#(
    parameter int MAX_CLUSTERS = 32
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    q_valid,
    output logic                         q_pop,
    input  wire cmd_t                    q_cmd,
    input  wire dims_t                   dims,
    input  wire logic                    out_ready,
    output logic                         out_valid,
    output logic [PORT_W-1:0]            rx_port,
    output logic [PORT_W-1:0]            tx_port,
    output logic signed [OUT_W-1:0]      chan_re,
    output logic signed [OUT_W-1:0]      chan_im,
    output logic                         last
);

    localparam int CL_W    = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int CA_W    = CL_W + 2 * PORT_W;
    localparam int P_W     = 2 * PORT_W;

    typedef enum logic [11:0] {
        B_IDLE   = 12'b000000000001,
        B_SQRT   = 12'b000000000010,
        B_CLRD   = 12'b000000000100,
        B_TSTART = 12'b000000001000,
        B_TWAIT  = 12'b000000010000,
        B_MAC    = 12'b000000100000,
        B_DRAIN  = 12'b000001000000,
        B_ORD    = 12'b000010000000,
        B_OMRE   = 12'b000100000000,
        B_OSRE   = 12'b001000000000,
        B_OSIM   = 12'b010000000000,
        B_OPUSH  = 12'b100000000000
    } bstate_t;

    logic [2*VAL_W-1:0]    coef_mem [1 << CA_W];
    logic [DLY_W-1:0]      dly_mem  [1 << CL_W];
    logic [2*TRIG_W-1:0]   dop_mem  [1 << CL_W];
    logic [2*ACC_W-1:0]    acc_mem  [1 << P_W];

    bstate_t                   state_reg, state_next;
    logic [FC_W-1:0]           fc_reg;
    logic [PSD_W-1:0]          psd_reg;
    dims_t                     dims_reg;
    logic [ROOT_W-1:0]         root_reg;
    logic [3:0]                bit_reg;
    logic [NC_W-1:0]           cl_reg;
    logic [PORT_W-1:0]         rx_reg;
    logic [PORT_W-1:0]         tx_reg;
    logic                      s1_valid_reg;
    logic                      s1_first_reg;
    logic [P_W-1:0]            s1_p_reg;
    logic                      s2_valid_reg;
    logic                      s2_first_reg;
    logic [P_W-1:0]            s2_p_reg;
    logic signed [ACC_W-1:0]   s2_re_reg;
    logic signed [ACC_W-1:0]   s2_im_reg;
    logic [2*VAL_W-1:0]        coef_rd_reg;
    logic [DLY_W-1:0]          dly_rd_reg;
    logic [2*TRIG_W-1:0]       dop_rd_reg;
    logic [2*ACC_W-1:0]        acc_rd_reg;
    logic signed [48:0]        hi_reg;
    logic [31:0]               lo_reg;
    logic signed [OUT_W-1:0]   res_re_reg;
    logic signed [OUT_W-1:0]   res_im_reg;
    logic                      out_valid_reg;
    logic [PORT_W-1:0]         rx_out_reg;
    logic [PORT_W-1:0]         tx_out_reg;
    logic signed [OUT_W-1:0]   re_out_reg;
    logic signed [OUT_W-1:0]   im_out_reg;
    logic                      last_out_reg;

    logic                      ph_start;
    logic                      ph_done;
    phasor_t                   ph;
    logic [ROOT_W-1:0]         sq_t_w;
    logic [31:0]               sq_w;
    logic                      rx_end_w;
    logic                      tx_end_w;
    logic                      cl_end_w;
    logic                      out_load_w;
    logic [P_W-1:0]            acc_raddr_w;
    logic                      acc_ren_w;
    logic signed [VAL_W-1:0]   ar_w;
    logic signed [VAL_W-1:0]   ai_w;
    logic signed [42:0]        mre_w;
    logic signed [42:0]        mim_w;
    logic [CL_W-1:0]           wcl_w;
    logic [CL_W-1:0]           rcl_w;
    logic signed [OUT_W-1:0]   scaled_w;
    logic                      is_rb_w;

    scs_phasor u_phasor (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (ph_start),
        .fc     (fc_reg),
        .delay  (dly_rd_reg),
        .dop_c  (dop_rd_reg[2*TRIG_W-1:TRIG_W]),
        .dop_s  (dop_rd_reg[TRIG_W-1:0]),
        .done   (ph_done),
        .phasor (ph)
    );

    function automatic logic signed [OUT_W-1:0] scale_sat(input logic signed [48:0] hi,
                                                          input logic [31:0] lo);
        logic signed [65:0] sum;
        logic signed [65:0] sh;
        logic signed [OUT_W-1:0] r;
        sum = ($signed(66'(hi)) <<< 16) + $signed({34'd0, lo});
        sh  = sum >>> 15;
        if (sh > $signed(66'(40'sh7f_ffff_ffff)))
            r = 40'sh7f_ffff_ffff;
        else if (sh < -$signed(66'h80_0000_0000))
            r = 40'sh80_0000_0000;
        else
            r = sh[OUT_W-1:0];
        return r;
    endfunction

    assign is_rb_w   = (q_cmd.op == OP_RB);
    assign q_pop     = (state_reg == B_IDLE) && q_valid;
    assign ph_start  = (state_reg == B_TSTART);
    assign sq_t_w    = root_reg | (ROOT_W'(1) << bit_reg);
    assign sq_w      = 32'(sq_t_w) * 32'(sq_t_w);
    assign rx_end_w  = ({1'b0, rx_reg} == dims_reg.nr - NP_W'(1));
    assign tx_end_w  = ({1'b0, tx_reg} == dims_reg.nt - NP_W'(1));
    assign cl_end_w  = (cl_reg == dims_reg.nc - NC_W'(1));
    assign out_load_w = (state_reg == B_OPUSH) && (!out_valid_reg || out_ready);
    assign wcl_w     = CL_W'(q_cmd.cluster);
    assign rcl_w     = cl_reg[CL_W-1:0];

    assign acc_ren_w   = s1_valid_reg || (state_reg == B_ORD);
    assign acc_raddr_w = (state_reg == B_ORD) ? {tx_reg, rx_reg} : s1_p_reg;

    assign ar_w  = coef_rd_reg[2*VAL_W-1:VAL_W];
    assign ai_w  = coef_rd_reg[VAL_W-1:0];
    assign mre_w = 43'(ar_w * ph.re) - 43'(ai_w * ph.im);
    assign mim_w = 43'(ar_w * ph.im) + 43'(ai_w * ph.re);
    assign scaled_w = scale_sat(hi_reg, lo_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:   if (q_valid && is_rb_w) state_next = B_SQRT;
            B_SQRT:   if (bit_reg == 4'd0) state_next = B_CLRD;
            B_CLRD:   state_next = B_TSTART;
            B_TSTART: state_next = B_TWAIT;
            B_TWAIT:  if (ph_done) state_next = B_MAC;
            B_MAC:    if (rx_end_w && tx_end_w) state_next = B_DRAIN;
            B_DRAIN:
                if (!s1_valid_reg && !s2_valid_reg)
                    state_next = cl_end_w ? B_ORD : B_CLRD;
            B_ORD:    state_next = B_OMRE;
            B_OMRE:   state_next = B_OSRE;
            B_OSRE:   state_next = B_OSIM;
            B_OSIM:   state_next = B_OPUSH;
            B_OPUSH:
                if (out_load_w)
                    state_next = (rx_end_w && tx_end_w) ? B_IDLE : B_ORD;
            default:  state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            s1_valid_reg <= (state_reg == B_MAC);
            s2_valid_reg <= s1_valid_reg;
            if (out_load_w)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // sequencer payload
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_IDLE:
            begin
                fc_reg   <= q_cmd.center_hz;
                psd_reg  <= q_cmd.psd;
                dims_reg <= dims;
                root_reg <= '0;
                bit_reg  <= 4'd15;
                cl_reg   <= '0;
                rx_reg   <= '0;
                tx_reg   <= '0;
            end
            B_SQRT:
            begin
                if (sq_w <= psd_reg)
                    root_reg <= sq_t_w;
                bit_reg <= bit_reg - 1'b1;
            end
            B_MAC:
            begin
                s1_p_reg     <= {tx_reg, rx_reg};
                s1_first_reg <= (cl_reg == '0);
                if (rx_end_w)
                begin
                    rx_reg <= '0;
                    tx_reg <= tx_end_w ? '0 : tx_reg + 1'b1;
                end
                else
                    rx_reg <= rx_reg + 1'b1;
            end
            B_DRAIN:
                if (!s1_valid_reg && !s2_valid_reg && !cl_end_w)
                    cl_reg <= cl_reg + 1'b1;
            B_OMRE:
            begin
                hi_reg <= $signed(acc_rd_reg[95:64]) * $signed({1'b0, root_reg});
                lo_reg <= 32'(acc_rd_reg[63:48]) * 32'(root_reg);
            end
            B_OSRE:
            begin
                res_re_reg <= scaled_w;
                hi_reg     <= $signed(acc_rd_reg[47:16]) * $signed({1'b0, root_reg});
                lo_reg     <= 32'(acc_rd_reg[15:0]) * 32'(root_reg);
            end
            B_OSIM:
                res_im_reg <= scaled_w;
            B_OPUSH:
                if (out_load_w)
                begin
                    if (rx_end_w)
                    begin
                        rx_reg <= '0;
                        tx_reg <= tx_end_w ? '0 : tx_reg + 1'b1;
                    end
                    else
                        rx_reg <= rx_reg + 1'b1;
                end
            default:
            begin
            end
        endcase
    end

    // MAC pipeline: stage 1 multiplies, stage 2 accumulates
    always_ff @(posedge clk)
    begin
        s2_p_reg     <= s1_p_reg;
        s2_first_reg <= s1_first_reg;
        s2_re_reg    <= ACC_W'(mre_w);
        s2_im_reg    <= ACC_W'(mim_w);
    end

    always_ff @(posedge clk)
    begin
        if (out_load_w)
        begin
            rx_out_reg   <= rx_reg;
            tx_out_reg   <= tx_reg;
            re_out_reg   <= res_re_reg;
            im_out_reg   <= res_im_reg;
            last_out_reg <= rx_end_w && tx_end_w;
        end
    end

    // stores
    always_ff @(posedge clk)
    begin
        if (q_pop && q_cmd.op == OP_COEF)
            coef_mem[{wcl_w, q_cmd.row, q_cmd.col}] <= {q_cmd.value_re, q_cmd.value_im};
        if (state_reg == B_MAC)
            coef_rd_reg <= coef_mem[{rcl_w, rx_reg, tx_reg}];
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && q_cmd.op == OP_CLUSTER)
        begin
            dly_mem[wcl_w] <= q_cmd.delay;
            dop_mem[wcl_w] <= {sat16(q_cmd.value_re), sat16(q_cmd.value_im)};
        end
        if (state_reg == B_CLRD)
        begin
            dly_rd_reg <= dly_mem[rcl_w];
            dop_rd_reg <= dop_mem[rcl_w];
        end
    end

    // first cluster overwrites, so no clearing of the accumulators is needed
    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            if (s2_first_reg)
                acc_mem[s2_p_reg] <= {s2_re_reg, s2_im_reg};
            else
                acc_mem[s2_p_reg] <= {acc_rd_reg[95:48] + s2_re_reg,
                                      acc_rd_reg[47:0] + s2_im_reg};
        end
        if (acc_ren_w)
            acc_rd_reg <= acc_mem[acc_raddr_w];
    end

    assign out_valid = out_valid_reg;
    assign rx_port   = rx_out_reg;
    assign tx_port   = tx_out_reg;
    assign chan_re   = re_out_reg;
    assign chan_im   = im_out_reg;
    assign last      = last_out_reg;

endmodule

`default_nettype wire

// ===== hdl/spectrum_channel_synthesis_top.sv =====
// ----------------------------------------------------------------------------
// spectrum_channel_synthesis_top
// Frequency-domain channel coefficient synthesis: coefficient and cluster
// loads, and per resource block one coefficient per rx/tx port pair.
//
//   channel | handshake          | payload
//   --------+--------------------+---------------------------------------------
//   in      | in_valid/in_ready  | opcode cluster row col value_re value_im
//           |                    | delay center_hz psd
//   out     | out_valid/out_ready| rx_port tx_port chan_re chan_im last
//   cfg     | cfg_valid/cfg_ready| cfg_index cfg_data
//
// Loads are written to the stores as the back end pops them; a short
// queue lets input run ahead. Per cluster the phasor unit evaluates 11
// Taylor terms, each one multiply and a 4-bit-per-cycle constant divider.
// Reset is asynchronous, active low; no store needs clearing after reset.
// Output stalls hold the back end; input stalls only when the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module spectrum_channel_synthesis_top
    import scs_pkg::*;
#(
    parameter int MAX_CLUSTERS = 32,
    parameter int MAX_PORTS    = 8
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [31:0]             cfg_data,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [1:0]              opcode,
    input  wire logic [4:0]              cluster,
    input  wire logic [PORT_W-1:0]       row,
    input  wire logic [PORT_W-1:0]       col,
    input  wire logic signed [VAL_W-1:0] value_re,
    input  wire logic signed [VAL_W-1:0] value_im,
    input  wire logic [DLY_W-1:0]        delay,
    input  wire logic [FC_W-1:0]         center_hz,
    input  wire logic [PSD_W-1:0]        psd,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [PORT_W-1:0]            rx_port,
    output logic [PORT_W-1:0]            tx_port,
    output logic signed [OUT_W-1:0]      chan_re,
    output logic signed [OUT_W-1:0]      chan_im,
    output logic                         last
);

    logic [5:0]      nc_reg;
    logic [NP_W-1:0] nr_reg;
    logic [NP_W-1:0] nt_reg;
    logic            rev_reg;
    dims_t           dims;
    logic            q_valid;
    logic            q_pop;
    cmd_t            q_cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nc_reg  <= 6'd1;
            nr_reg  <= 4'd1;
            nt_reg  <= 4'd1;
            rev_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_NUM_CLUSTERS: nc_reg  <= cfg_data[5:0];
                CFG_NUM_RX:       nr_reg  <= cfg_data[NP_W-1:0];
                CFG_NUM_TX:       nt_reg  <= cfg_data[NP_W-1:0];
                CFG_REVERSE:      rev_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // clamp register values into 1..max
    always_comb
    begin
        if (nc_reg == '0)
            dims.nc = NC_W'(1);
        else if ({1'b0, nc_reg} > NC_W'(MAX_CLUSTERS))
            dims.nc = NC_W'(MAX_CLUSTERS);
        else
            dims.nc = {1'b0, nc_reg};

        if (nr_reg == '0)
            dims.nr = NP_W'(1);
        else if (nr_reg > NP_W'(MAX_PORTS))
            dims.nr = NP_W'(MAX_PORTS);
        else
            dims.nr = nr_reg;

        if (nt_reg == '0)
            dims.nt = NP_W'(1);
        else if (nt_reg > NP_W'(MAX_PORTS))
            dims.nt = NP_W'(MAX_PORTS);
        else
            dims.nt = nt_reg;
    end

    scs_front #(
        .MAX_CLUSTERS (MAX_CLUSTERS),
        .MAX_PORTS    (MAX_PORTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .cluster   (cluster),
        .row       (row),
        .col       (col),
        .value_re  (value_re),
        .value_im  (value_im),
        .delay     (delay),
        .center_hz (center_hz),
        .psd       (psd),
        .reverse   (rev_reg),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_cmd     (q_cmd)
    );

    scs_back #(
        .MAX_CLUSTERS (MAX_CLUSTERS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_cmd     (q_cmd),
        .dims      (dims),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .rx_port   (rx_port),
        .tx_port   (tx_port),
        .chan_re   (chan_re),
        .chan_im   (chan_im),
        .last      (last)
    );

endmodule

`default_nettype wire

// ===== tb/scs_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scs_checker
// Watches the config, input and output channels of the channel synthesis
// block, predicts every coefficient of each resource block from its own copy
// of the stores and registers, and compares each output transaction in order.
// ----------------------------------------------------------------------------
module scs_checker
    import scs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]             cfg_data,
    input  logic                    in_valid,
    input  logic                    in_ready,
    input  logic [1:0]              opcode,
    input  logic [4:0]              cluster,
    input  logic [PORT_W-1:0]       row,
    input  logic [PORT_W-1:0]       col,
    input  logic signed [VAL_W-1:0] value_re,
    input  logic signed [VAL_W-1:0] value_im,
    input  logic [DLY_W-1:0]        delay,
    input  logic [FC_W-1:0]         center_hz,
    input  logic [PSD_W-1:0]        psd,
    input  logic                    out_valid,
    input  logic                    out_ready,
    input  logic [PORT_W-1:0]       rx_port,
    input  logic [PORT_W-1:0]       tx_port,
    input  logic signed [OUT_W-1:0] chan_re,
    input  logic signed [OUT_W-1:0] chan_im,
    input  logic                    last,
    output int                      mismatches,
    output int                      outstanding
);

    typedef struct {
        logic [PORT_W-1:0]       rx;
        logic [PORT_W-1:0]       tx;
        logic signed [OUT_W-1:0] re;
        logic signed [OUT_W-1:0] im;
        logic                    fin;
    } coef_out_t;

    localparam longint SAT_HI = 64'sd549755813887;
    localparam longint SAT_LO = -64'sd549755813888;

    logic signed [VAL_W-1:0] lt_re [32][8][8];
    logic signed [VAL_W-1:0] lt_im [32][8][8];
    logic [DLY_W-1:0]        clu_delay [32];
    logic signed [15:0]      dop_re [32];
    logic signed [15:0]      dop_im [32];

    logic [5:0] reg_nc;
    logic [3:0] reg_nr;
    logic [3:0] reg_nt;
    logic       reg_rev;

    coef_out_t coef_q[$];

    function automatic longint sat_q15(input longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic longint to_q15(input longint v);
        if (v < 0)
            v = 0;
        return (v + 16384) >>> 15;
    endfunction

    // cos/sin of 2*pi*idx/65536 in Q1.15, Taylor series per quadrant
    function automatic void trig_lookup(input logic [15:0] idx,
                                        output longint c, output longint s);
        longint unsigned x, x2, t;
        longint sa, ca, sv, cv;
        x = (longint'(idx[13:0]) * longint'(HALF_PI_Q30)) >> 14;
        x2 = (x * x) >> 30;
        t = x;
        sa = x;
        for (int k = 1; k <= 5; k++)
        begin
            t = ((t * x2) >> 30) / ((2 * k) * (2 * k + 1));
            if (k % 2) sa -= t; else sa += t;
        end
        t = 64'd1 << 30;
        ca = t;
        for (int k = 1; k <= 6; k++)
        begin
            t = ((t * x2) >> 30) / ((2 * k - 1) * (2 * k));
            if (k % 2) ca -= t; else ca += t;
        end
        sv = to_q15(sa);
        cv = to_q15(ca);
        case (idx[15:14])
            2'd0:
            begin
                c = cv; s = sv;
            end
            2'd1:
            begin
                c = -sv; s = cv;
            end
            2'd2:
            begin
                c = -cv; s = -sv;
            end
            default:
            begin
                c = sv; s = -cv;
            end
        endcase
        c = sat_q15(c);
        s = sat_q15(s);
    endfunction

    function automatic longint floor_root(input logic [31:0] v);
        longint unsigned r, t;
        r = 0;
        for (int b = 15; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    function automatic int clamp_dim(input int v, input int hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    task automatic predict_block(input logic [FC_W-1:0] fc, input logic [31:0] p);
        longint acc_re [64];
        longint acc_im [64];
        longint root, tc, ts, dc, ds, pr, pi, ar, ai, v;
        longint unsigned ph;
        int nc, nr, nt, k;
        coef_out_t e;
        nc = clamp_dim(reg_nc, 32);
        nr = clamp_dim(reg_nr, 8);
        nt = clamp_dim(reg_nt, 8);
        root = floor_root(p);
        for (int i = 0; i < 64; i++)
        begin
            acc_re[i] = 0;
            acc_im[i] = 0;
        end
        for (int c = 0; c < nc; c++)
        begin
            ph = (64'd0 - longint'(fc) * longint'(clu_delay[c])) & 64'hFFFF_FFFF_FFFF;
            trig_lookup(ph[47:32], tc, ts);
            dc = dop_re[c];
            ds = dop_im[c];
            pr = (tc * dc - ts * ds) >>> 15;
            pi = (tc * ds + ts * dc) >>> 15;
            for (int tx = 0; tx < nt; tx++)
                for (int rx = 0; rx < nr; rx++)
                begin
                    ar = lt_re[c][rx][tx];
                    ai = lt_im[c][rx][tx];
                    k = rx + nr * tx;
                    acc_re[k] += ar * pr - ai * pi;
                    acc_im[k] += ar * pi + ai * pr;
                end
        end
        for (int tx = 0; tx < nt; tx++)
            for (int rx = 0; rx < nr; rx++)
            begin
                k = rx + nr * tx;
                e.rx = rx;
                e.tx = tx;
                v = (acc_re[k] * root) >>> 15;
                e.re = (v > SAT_HI) ? SAT_HI : (v < SAT_LO) ? SAT_LO : v;
                v = (acc_im[k] * root) >>> 15;
                e.im = (v > SAT_HI) ? SAT_HI : (v < SAT_LO) ? SAT_LO : v;
                e.fin = (tx == nt - 1) && (rx == nr - 1);
                coef_q.push_back(e);
            end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        coef_out_t e;
        logic [2:0] r, c;
        if (!rst_n)
        begin
            reg_nc <= 6'd1;
            reg_nr <= 4'd1;
            reg_nt <= 4'd1;
            reg_rev <= 1'b0;
            coef_q.delete();
            mismatches = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_NUM_CLUSTERS: reg_nc <= cfg_data[5:0];
                    CFG_NUM_RX:       reg_nr <= cfg_data[3:0];
                    CFG_NUM_TX:       reg_nt <= cfg_data[3:0];
                    CFG_REVERSE:      reg_rev <= cfg_data[0];
                    default:          ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                case (op_t'(opcode))
                    OP_COEF:
                    begin
                        r = reg_rev ? col : row;
                        c = reg_rev ? row : col;
                        lt_re[cluster][r][c] = value_re;
                        lt_im[cluster][r][c] = value_im;
                    end
                    OP_CLUSTER:
                    begin
                        clu_delay[cluster] = delay;
                        dop_re[cluster] = sat16(value_re);
                        dop_im[cluster] = sat16(value_im);
                    end
                    OP_RB: predict_block(center_hz, psd);
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (coef_q.size() == 0)
                begin
                    $error("unexpected output transaction: rx %0d tx %0d", rx_port, tx_port);
                    mismatches++;
                end
                else
                begin
                    e = coef_q.pop_front();
                    if (rx_port !== e.rx)
                    begin
                        $error("rx_port: expected %0d, actual %0d", e.rx, rx_port);
                        mismatches++;
                    end
                    if (tx_port !== e.tx)
                    begin
                        $error("tx_port: expected %0d, actual %0d", e.tx, tx_port);
                        mismatches++;
                    end
                    if (chan_re !== e.re)
                    begin
                        $error("chan_re: expected %0d, actual %0d", e.re, chan_re);
                        mismatches++;
                    end
                    if (chan_im !== e.im)
                    begin
                        $error("chan_im: expected %0d, actual %0d", e.im, chan_im);
                        mismatches++;
                    end
                    if (last !== e.fin)
                    begin
                        $error("last: expected %0d, actual %0d", e.fin, last);
                        mismatches++;
                    end
                end
            end
            outstanding = coef_q.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the channel synthesis block: preloads every store, runs
// directed corner items, then random loads and resource blocks over several
// register settings, with random idling on both channels in most of them.
// ----------------------------------------------------------------------------
module testbench;
    import scs_pkg::*;

    localparam int DRAIN_CYCLES = 64;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [31:0]             cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [1:0]              opcode = '0;
    logic [4:0]              cluster = '0;
    logic [PORT_W-1:0]       row = '0;
    logic [PORT_W-1:0]       col = '0;
    logic signed [VAL_W-1:0] value_re = '0;
    logic signed [VAL_W-1:0] value_im = '0;
    logic [DLY_W-1:0]        delay = '0;
    logic [FC_W-1:0]         center_hz = '0;
    logic [PSD_W-1:0]        psd = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [PORT_W-1:0]       rx_port;
    logic [PORT_W-1:0]       tx_port;
    logic signed [OUT_W-1:0] chan_re;
    logic signed [OUT_W-1:0] chan_im;
    logic                    last;

    int  mismatches;
    int  outstanding;
    bit  steady = 1'b0;      // no idling on either side
    int  hold_reqs = 0;

    spectrum_channel_synthesis_top DUT (.*);

    scs_checker u_checker (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #60_000_000;
        $display("testbench: errors");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int seen;
        seen = 0;
        forever
        begin
            @(posedge clk);
            if (hold_reqs != seen)
            begin
                seen = hold_reqs;
                out_ready <= 1'b0;
                repeat (3000) @(posedge clk);
            end
            else if (steady)
                out_ready <= 1'b1;
            else if ($urandom_range(0, 299) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(20, 90)) @(posedge clk);
            end
            else
                out_ready <= ($urandom_range(0, 99) < 75);
        end
    end

    function automatic int idle_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    task automatic send(input cmd_t c);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= c.op;
        cluster   <= c.cluster;
        row       <= c.row;
        col       <= c.col;
        value_re  <= c.value_re;
        value_im  <= c.value_im;
        delay     <= c.delay;
        center_hz <= c.center_hz;
        psd       <= c.psd;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    function automatic cmd_t noise_cmd(input op_t op);
        cmd_t c;
        c.op = op;
        c.cluster = $urandom;
        c.row = $urandom;
        c.col = $urandom;
        c.value_re = $urandom;
        c.value_im = $urandom;
        c.delay = $urandom;
        c.center_hz = {$urandom, $urandom};
        c.psd = $urandom;
        return c;
    endfunction

    function automatic cmd_t load_coef(input int cl, input int r, input int cc,
                                       input int re, input int im);
        cmd_t c;
        c = noise_cmd(OP_COEF);
        c.cluster = cl;
        c.row = r;
        c.col = cc;
        c.value_re = re;
        c.value_im = im;
        return c;
    endfunction

    function automatic cmd_t load_cluster(input int cl, input logic [31:0] d,
                                          input int re, input int im);
        cmd_t c;
        c = noise_cmd(OP_CLUSTER);
        c.cluster = cl;
        c.delay = d;
        c.value_re = re;
        c.value_im = im;
        return c;
    endfunction

    function automatic cmd_t rb(input logic [FC_W-1:0] fc, input logic [31:0] p);
        cmd_t c;
        c = noise_cmd(OP_RB);
        c.center_hz = fc;
        c.psd = p;
        return c;
    endfunction

    function automatic int rand_val();
        if ($urandom_range(0, 1))
            return $urandom_range(0, 80000) - 40000;
        return $signed($urandom) >>> 8;
    endfunction

    function automatic cmd_t random_cmd();
        int r;
        logic [31:0] p;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            case ($urandom_range(0, 3))
                0: p = 0;
                1: p = $urandom_range(1, 255);
                2: p = $urandom;
                default: p = $urandom >> $urandom_range(0, 31);
            endcase
            return rb({$urandom, $urandom}, p);
        end
        if (r < 80)
            return load_coef($urandom_range(0, 31), $urandom_range(0, 7),
                             $urandom_range(0, 7), rand_val(), rand_val());
        if (r < 96)
            return load_cluster($urandom_range(0, 31), $urandom, rand_val(), rand_val());
        return noise_cmd(OP_NONE);
    endfunction

    // results drained, then room for loads still in flight
    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(input int nc, input int nr, input int nt, input int rev);
        logic [31:0] vals [4];
        vals[0] = (nc & 32'h3F) | ($urandom & ~32'h3F);
        vals[1] = (nr & 32'hF) | ($urandom & ~32'hF);
        vals[2] = (nt & 32'hF) | ($urandom & ~32'hF);
        vals[3] = (rev & 1) | ($urandom & ~32'h1);
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= i;
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int phase_cfg [10][5];
        phase_cfg = '{'{2, 2, 2, 1, 30}, '{4, 3, 2, 0, 30}, '{1, 8, 8, 1, 25},
                      '{32, 1, 1, 0, 12}, '{3, 1, 4, 1, 30}, '{0, 0, 0, 0, 30},
                      '{63, 15, 15, 1, 6}, '{5, 2, 3, 0, 30}, '{8, 4, 4, 1, 25},
                      '{2, 7, 1, 0, 30}};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every store entry so no read ever hits an unwritten one
        steady = 1'b1;
        for (int cl = 0; cl < 32; cl++)
        begin
            send(load_cluster(cl, $urandom, rand_val(), rand_val()));
            for (int r = 0; r < 8; r++)
                for (int cc = 0; cc < 8; cc++)
                    send(load_coef(cl, r, cc, rand_val(), rand_val()));
        end
        steady = 1'b0;
        wait_drain();

        // unused register index, then one cluster and one port pair
        cfg_valid <= 1'b1;
        cfg_index <= 3'd7;
        cfg_data  <= $urandom;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        write_regs(1, 1, 1, 0);

        send(load_coef(0, 0, 0, 8388607, 8388607));
        send(load_cluster(0, 0, 8388607, 0));        // wide Doppler saturates
        send(rb(37'h1F_FFFF_FFFF, 32'hFFFF_FFFF));   // output close to full scale
        send(load_coef(0, 0, 0, -8388608, -8388608));
        send(load_cluster(0, 0, -8388608, -8388608));
        send(rb(0, 32'hFFFF_FFFF));
        send(rb(37'h1_2345_6789, 0));                // zero PSD
        send(noise_cmd(OP_NONE));
        send(load_cluster(0, 32'hFFFF_FFFF, 12345, -2000));
        send(rb(37'd3500000000, 1000));
        send(rb(37'h1F_FFFF_FFFF, 1));
        send(load_coef(0, 0, 0, 0, 0));
        send(rb(37'd28000000000, 32'hFFFF_FFFF));
        send(load_coef(0, 0, 0, 1, -1));
        send(load_cluster(0, 32'h8000_0000, 32767, 32767));
        send(rb(37'd6000000000, 65536));

        for (int ph = 0; ph < 10; ph++)
        begin
            wait_drain();
            write_regs(phase_cfg[ph][0], phase_cfg[ph][1], phase_cfg[ph][2],
                       phase_cfg[ph][3]);
            steady = (ph % 4 == 2);
            if (ph == 0)
            begin
                // receiver holds off while resource blocks pile up
                hold_reqs++;
                for (int i = 0; i < 12; i++)
                    send(rb({$urandom, $urandom}, $urandom));
            end
            for (int i = 0; i < phase_cfg[ph][4]; i++)
                send(random_cmd());
        end
        steady = 1'b0;
        wait_drain();

        if (mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/scs_pkg.sv
hdl/scs_front.sv
hdl/scs_phasor.sv
hdl/scs_back.sv
hdl/spectrum_channel_synthesis_top.sv
tb/scs_checker.sv
tb/testbench.sv
